FILE: hw/rtl/clts_pkg.sv
// ============================================================================
// clts_pkg: shared definitions for the C-like token scanner
// Scanner mode codes, token kind codes, keyword table and the record type.
// ============================================================================
package clts_pkg;

    // Default parameter values.
    localparam int MAX_TOKEN_LENGTH_DEF = 255;
    localparam int POSITION_BITS_DEF    = 32;

    // Result queue depth; one accepted byte may push two records.
    localparam int FIFO_DEPTH = 4;

    // Scanner modes.
    localparam logic [2:0] M_IDLE   = 3'd0;
    localparam logic [2:0] M_IDENT  = 3'd1;
    localparam logic [2:0] M_NUMBER = 3'd2;
    localparam logic [2:0] M_STRING = 3'd3;
    localparam logic [2:0] M_SLASH  = 3'd4;
    localparam logic [2:0] M_LINE   = 3'd5;
    localparam logic [2:0] M_BLOCK  = 3'd6;
    localparam logic [2:0] M_BSTAR  = 3'd7;

    // Token kinds.
    localparam logic [3:0] K_KEYWORD  = 4'd0;
    localparam logic [3:0] K_IDENT    = 4'd1;
    localparam logic [3:0] K_NUMBER   = 4'd2;
    localparam logic [3:0] K_OPERATOR = 4'd3;
    localparam logic [3:0] K_DELIM    = 4'd4;
    localparam logic [3:0] K_STRING   = 4'd5;
    localparam logic [3:0] K_LINE     = 4'd6;
    localparam logic [3:0] K_BLOCK    = 4'd7;
    localparam logic [3:0] K_UNKNOWN  = 4'd8;

    localparam int KW_COUNT = 6;

    // Keyword text, first character in the top byte, zero padded.
    localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
        {"int",    24'd0},
        {"float",  8'd0},
        {"if",     32'd0},
        {"else",   16'd0},
        {"while",  8'd0},
        {"return"}
    };

    localparam logic [7:0] KW_LEN [KW_COUNT] = '{8'd3, 8'd5, 8'd2, 8'd4, 8'd5, 8'd6};

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef struct packed {
        logic [3:0]  kind;
        logic [2:0]  kw;
        logic [31:0] start;
        logic [7:0]  len;
        logic [7:0]  sym;
        logic        unterm;
        logic        last;
    } t_tok;

    function automatic logic is_letter(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    endfunction

    function automatic logic is_numch(input logic [7:0] c);
        return c inside {[8'h30:8'h39], 8'h2E};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    // Clear the keyword candidates that disagree with byte c at offset p.
    function automatic logic [KW_COUNT-1:0] match_update(input logic [KW_COUNT-1:0] m,
                                                         input logic [7:0] p,
                                                         input logic [7:0] c);
        logic [KW_COUNT-1:0] r;
        logic [2:0]          q;
        r = m;
        q = p[2:0];
        for (int k = 0; k < KW_COUNT; k++) begin
            if (p >= KW_LEN[k]) begin
                r[k] = 1'b0;
            end else if (KW_TEXT[k][8*(5-q) +: 8] != c) begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/c_like_token_scanner_top.sv
// ============================================================================
// c_like_token_scanner_top: streaming lexer for a small C-like language
// Scans one source byte per request and queues a token record per token.
// ============================================================================
// Usage:
//   The input channel (i_valid / o_ready) carries one source byte per request,
//   with i_end_of_text marking the final byte of a text. The output channel
//   (o_valid / i_ready) carries one token record per request. A byte may close
//   up to two tokens; o_last_of_run marks the final record caused by a byte.
//   The scanner state is updated in the cycle the byte is accepted and the
//   records are written into a four-entry result queue; a record reaches the
//   output port once the records ahead of it are taken. A byte is taken every
//   cycle as long as the queue has room for two records; o_ready therefore
//   drops only when the queue holds more than two records, which happens
//   when the receiver stalls or when bytes close two tokens back to back.
//   Sustained rate is one byte per cycle while o_ready is high; the records
//   of a two-record byte drain at one record per cycle while i_ready is high.
//   Reset returns the scanner to idle, clears the byte offset, the length
//   count and the result queue, and sets all keyword candidates.
// ============================================================================
module c_like_token_scanner_top #(
    parameter int MAX_TOKEN_LENGTH = clts_pkg::MAX_TOKEN_LENGTH_DEF,
    parameter int POSITION_BITS    = clts_pkg::POSITION_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_end_of_text,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_token_kind,
    output logic [2:0] o_keyword_index,
    output logic [31:0] o_token_start,
    output logic [7:0] o_token_length,
    output logic [7:0] o_symbol,
    output logic       o_unterminated,
    output logic       o_last_of_run
);
    import clts_pkg::*;

    localparam logic [7:0] LEN_CAP = (MAX_TOKEN_LENGTH < 255) ? 8'(MAX_TOKEN_LENGTH) : 8'd255;
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(FIFO_DEPTH - 2);

    // Scanner state.
    logic [2:0]               r_mode;
    logic [KW_COUNT-1:0]      r_kwm;
    logic [POSITION_BITS-1:0] r_start;
    logic [7:0]               r_len;
    logic [POSITION_BITS-1:0] r_pos;

    // Result queue.
    t_tok                     r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]         r_wr;
    logic [PTR_W-1:0]         r_rd;
    logic [CNT_W-1:0]         r_cnt;

    logic                     accept;
    logic                     pop;

    // Next-state and record values for the byte on the input port.
    logic [2:0]               n_mode;
    logic [KW_COUNT-1:0]      n_kwm;
    logic [POSITION_BITS-1:0] n_start;
    logic [7:0]               n_len;
    t_tok                     rec [2];
    logic [1:0]               rec_n;

    function automatic logic [31:0] to32(input logic [POSITION_BITS-1:0] v);
        logic [POSITION_BITS+31:0] e;
        e = {32'd0, v};
        return e[31:0];
    endfunction

    function automatic logic [7:0] grow(input logic [7:0] l);
        return (l < LEN_CAP) ? l + 8'd1 : l;
    endfunction

    // Record for a token that is still open in mode m.
    function automatic t_tok finish_rec(input logic [2:0] m, input logic [KW_COUNT-1:0] kwm,
                                        input logic [31:0] st, input logic [7:0] ln);
        t_tok t;
        t = '0;
        t.start = st;
        t.len   = ln;
        case (m)
            M_IDENT: begin
                t.kind = K_IDENT;
                // Walk downward so that the lowest matching keyword wins.
                for (int k = KW_COUNT - 1; k >= 0; k--) begin
                    if (kwm[k] && ln == KW_LEN[k]) begin
                        t.kind = K_KEYWORD;
                        t.kw   = 3'(k);
                    end
                end
            end
            M_NUMBER: t.kind = K_NUMBER;
            M_STRING: begin
                t.kind   = K_STRING;
                t.unterm = 1'b1;
            end
            M_SLASH: begin
                t.kind = K_OPERATOR;
                t.sym  = CH_SLASH;
            end
            M_LINE:  t.kind = K_LINE;
            M_BLOCK, M_BSTAR: begin
                t.kind   = K_BLOCK;
                t.unterm = 1'b1;
            end
            default: t.kind = K_UNKNOWN;
        endcase
        return t;
    endfunction

    function automatic t_tok simple_rec(input logic [3:0] kind, input logic [31:0] st,
                                        input logic [7:0] ln, input logic [7:0] sym);
        t_tok t;
        t       = '0;
        t.kind  = kind;
        t.start = st;
        t.len   = ln;
        t.sym   = sym;
        return t;
    endfunction

    always_comb begin
        logic       do_finish;
        logic       do_fresh;
        logic [7:0] c;
        c         = i_char_in;
        n_mode    = r_mode;
        n_kwm     = r_kwm;
        n_start   = r_start;
        n_len     = r_len;
        rec[0]    = '0;
        rec[1]    = '0;
        rec_n     = 2'd0;
        do_finish = 1'b0;
        do_fresh  = 1'b0;

        case (r_mode)
            M_IDENT: begin
                if (is_letter(c) || is_numch(c)) begin
                    n_kwm = match_update(r_kwm, r_len, c);
                    n_len = grow(r_len);
                end else begin
                    do_finish = 1'b1;
                    do_fresh  = 1'b1;
                end
            end
            M_NUMBER: begin
                if (is_numch(c)) begin
                    n_len = grow(r_len);
                end else begin
                    do_finish = 1'b1;
                    do_fresh  = 1'b1;
                end
            end
            M_STRING: begin
                n_len = grow(r_len);
                if (c == CH_QUOTE) begin
                    rec[0] = simple_rec(K_STRING, to32(r_start), n_len, 8'd0);
                    rec_n  = 2'd1;
                    n_mode = M_IDLE;
                end
            end
            M_SLASH: begin
                if (c == CH_SLASH) begin
                    n_len  = grow(r_len);
                    n_mode = M_LINE;
                end else if (c == CH_STAR) begin
                    n_len  = grow(r_len);
                    n_mode = M_BLOCK;
                end else begin
                    do_finish = 1'b1;
                    do_fresh  = 1'b1;
                end
            end
            M_LINE: begin
                if (c == CH_LF) begin
                    rec[0] = simple_rec(K_LINE, to32(r_start), r_len, 8'd0);
                    rec_n  = 2'd1;
                    n_mode = M_IDLE;
                end else begin
                    n_len = grow(r_len);
                end
            end
            M_BLOCK: begin
                n_len = grow(r_len);
                if (c == CH_STAR) begin
                    n_mode = M_BSTAR;
                end
            end
            M_BSTAR: begin
                n_len = grow(r_len);
                if (c == CH_SLASH) begin
                    rec[0] = simple_rec(K_BLOCK, to32(r_start), n_len, 8'd0);
                    rec_n  = 2'd1;
                    n_mode = M_IDLE;
                end else if (c != CH_STAR) begin
                    n_mode = M_BLOCK;
                end
            end
            default: begin
                n_mode   = M_IDLE;
                do_fresh = 1'b1;
            end
        endcase

        // A byte that cannot extend the open token closes it.
        if (do_finish) begin
            rec[0] = finish_rec(r_mode, r_kwm, to32(r_start), r_len);
            rec_n  = 2'd1;
            n_mode = M_IDLE;
        end

        // Scan the byte as the start of a new token.
        if (do_fresh && !is_space(c)) begin
            n_start = r_pos;
            n_len   = 8'd1;
            if (is_letter(c)) begin
                n_kwm  = match_update({KW_COUNT{1'b1}}, 8'd0, c);
                n_mode = M_IDENT;
            end else if (is_numch(c)) begin
                n_mode = M_NUMBER;
            end else if (c == CH_QUOTE) begin
                n_mode = M_STRING;
            end else if (c == CH_SLASH) begin
                n_mode = M_SLASH;
            end else begin
                n_len = r_len;
                n_start = r_start;
                rec[rec_n[0]] = simple_rec(
                    (c inside {8'h2B, 8'h2D, 8'h2A, 8'h3D}) ? K_OPERATOR :
                    (c inside {8'h3B, 8'h2C, 8'h28, 8'h29}) ? K_DELIM : K_UNKNOWN,
                    to32(r_pos), 8'd1, c);
                rec_n = rec_n + 2'd1;
            end
        end

        // End of text flushes whatever is still open.
        if (i_end_of_text && n_mode != M_IDLE) begin
            rec[rec_n[0]] = finish_rec(n_mode, n_kwm, to32(n_start), n_len);
            rec_n  = rec_n + 2'd1;
            n_mode = M_IDLE;
        end

        if (rec_n == 2'd2) begin
            rec[1].last = 1'b1;
        end else if (rec_n == 2'd1) begin
            rec[0].last = 1'b1;
        end
    end

    assign o_ready = (r_cnt <= ROOM_LIMIT);
    assign accept  = i_valid && o_ready;
    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_ready;

    // Scanner state and queue control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_kwm   <= {KW_COUNT{1'b1}};
            r_start <= '0;
            r_len   <= 8'd0;
            r_pos   <= '0;
            r_wr    <= '0;
            r_rd    <= '0;
            r_cnt   <= '0;
        end else begin
            if (accept) begin
                r_mode  <= n_mode;
                r_kwm   <= n_kwm;
                r_start <= n_start;
                r_len   <= n_len;
                r_pos   <= r_pos + POSITION_BITS'(1);
                r_wr    <= r_wr + PTR_W'(rec_n);
            end
            if (pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            r_cnt <= r_cnt + (accept ? CNT_W'(rec_n) : CNT_W'(0)) - (pop ? CNT_W'(1) : CNT_W'(0));
        end
    end

    // Queue payload, no reset needed.
    always_ff @(posedge i_clk) begin
        if (accept && rec_n != 2'd0) begin
            r_fifo[r_wr] <= rec[0];
        end
        if (accept && rec_n == 2'd2) begin
            r_fifo[r_wr + PTR_W'(1)] <= rec[1];
        end
    end

    assign o_token_kind    = r_fifo[r_rd].kind;
    assign o_keyword_index = r_fifo[r_rd].kw;
    assign o_token_start   = r_fifo[r_rd].start;
    assign o_token_length  = r_fifo[r_rd].len;
    assign o_symbol        = r_fifo[r_rd].sym;
    assign o_unterminated  = r_fifo[r_rd].unterm;
    assign o_last_of_run   = r_fifo[r_rd].last;

endmodule
